// ----- hw/rtl/wec_pkg.sv -----
// ----------------------------------------------------------------------------
// wec_pkg
// Shared types and constants of the window edge classifier: item and record
// layouts, configuration register indexes and reset values.
// ----------------------------------------------------------------------------
package wec_pkg;

  localparam int MAX_WIDTH_DEF  = 1024;
  localparam int MAX_HEIGHT_DEF = 1024;

  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 11;

  localparam int       DIM_RESET    = 1024;
  localparam logic [7:0] THRESH_RESET = 8'd20;
  localparam logic [7:0] PEL_MAX      = 8'd255;

  // window geometry: 3 by 3, centre in the middle
  localparam int WIN_SIDE = 3;
  localparam int WIN_SIZE = WIN_SIDE * WIN_SIDE;
  localparam int CENTRE   = 4;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_IMAGE_WIDTH    = 2'd0,
    REG_IMAGE_HEIGHT   = 2'd1,
    REG_EDGE_THRESHOLD = 2'd2
  } cfg_reg_t;

  localparam logic OP_PIXEL = 1'b0;
  localparam logic OP_FLUSH = 1'b1;

  typedef logic [7:0] pel_t;

  typedef struct packed {
    logic opcode;
    pel_t pixel;
  } pix_item_t;

  typedef struct packed {
    logic [9:0] edge_x;
    logic [9:0] edge_y;
    pel_t       window_min;
    pel_t       low_band_max;
    pel_t       window_max;
    pel_t       high_band_min;
  } edge_rec_t;

  // assembled window with the centre position
  typedef struct packed {
    pel_t [WIN_SIZE-1:0] px;
    logic [9:0]          cx;
    logic [9:0]          cy;
  } win_t;

  typedef struct packed {
    logic valid;
    logic advance;
  } pipe_ctl_t;

endpackage

// ----- hw/rtl/wec_ram.sv -----
// ----------------------------------------------------------------------------
// wec_ram
// Simple dual-port RAM: one write port, one read port, registered read data.
// A read and a write to the same address in one cycle return the old data.
// ----------------------------------------------------------------------------
module wec_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic                     rd_en,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

// ----- hw/rtl/wec_classify.sv -----
// ----------------------------------------------------------------------------
// wec_classify
// Three-stage classifier: window extremes, band flags, then counts and the
// record decision. Advances in step with the front end.
// ----------------------------------------------------------------------------
module wec_classify (
  input  logic               clk,
  input  logic               rst,
  input  wec_pkg::pipe_ctl_t ctl,
  input  wec_pkg::win_t      win,
  input  wec_pkg::pel_t      thr,
  output logic               res_valid,
  output wec_pkg::edge_rec_t res
);
  import wec_pkg::*;

  // stage 2: extremes
  logic                s2_valid;
  win_t                s2_win;
  pel_t                lo_c;
  pel_t                hi_c;

  // stage 3: band flags
  logic                s3_valid;
  win_t                s3_win;
  pel_t                s3_lo;
  pel_t                s3_hi;
  pel_t                half;
  logic [8:0]          lo_band;
  logic                cand_c;
  logic [WIN_SIZE-1:0] low_c;
  logic [WIN_SIZE-1:0] high_c;

  // stage 4: counts and decision
  logic                s4_valid;
  win_t                s4_win;
  pel_t                s4_lo;
  pel_t                s4_hi;
  logic                s4_cand;
  logic [WIN_SIZE-1:0] s4_low;
  logic [WIN_SIZE-1:0] s4_high;
  logic [3:0]          nlow;
  logic [3:0]          nhigh;
  pel_t                low_max;
  pel_t                high_min;
  logic                hit;

  always_comb begin
    lo_c = PEL_MAX;
    hi_c = '0;
    for (int k = 0; k < WIN_SIZE; k++) begin
      if (s2_win.px[k] < lo_c) lo_c = s2_win.px[k];
      if (s2_win.px[k] > hi_c) hi_c = s2_win.px[k];
    end
  end

  always_comb begin
    half    = thr >> 1;
    lo_band = {1'b0, s3_lo} + {1'b0, half};
    cand_c  = (({1'b0, s3_lo} + {1'b0, thr}) <= {1'b0, s3_hi}) &&
              ({1'b0, s3_win.px[CENTRE]} >= lo_band) &&
              (({1'b0, s3_win.px[CENTRE]} + {1'b0, half}) <= {1'b0, s3_hi});
    for (int k = 0; k < WIN_SIZE; k++) begin
      low_c[k]  = {1'b0, s3_win.px[k]} < lo_band;
      high_c[k] = ({1'b0, s3_win.px[k]} + {1'b0, half}) > {1'b0, s3_hi};
    end
  end

  always_comb begin
    nlow     = '0;
    nhigh    = '0;
    low_max  = '0;
    high_min = PEL_MAX;
    for (int k = 0; k < WIN_SIZE; k++) begin
      nlow  = nlow + 4'(s4_low[k]);
      nhigh = nhigh + 4'(s4_high[k]);
      if (s4_low[k] && s4_win.px[k] > low_max) low_max = s4_win.px[k];
      if (s4_high[k] && s4_win.px[k] < high_min) high_min = s4_win.px[k];
    end
    hit = s4_cand && ((nlow >= 4'd2 && nhigh >= 4'd2) ||
                      (nlow == 4'd1 && nhigh >= 4'd3) ||
                      (nhigh == 4'd1 && nlow >= 4'd3));
  end

  assign res_valid         = s4_valid && hit;
  assign res.edge_x        = s4_win.cx;
  assign res.edge_y        = s4_win.cy;
  assign res.window_min    = s4_lo;
  assign res.low_band_max  = low_max;
  assign res.window_max    = s4_hi;
  assign res.high_band_min = high_min;

  always_ff @(posedge clk) begin
    if (rst) begin
      s2_valid <= 1'b0;
      s3_valid <= 1'b0;
      s4_valid <= 1'b0;
    end else if (ctl.advance) begin
      s2_valid <= ctl.valid;
      s3_valid <= s2_valid;
      s4_valid <= s3_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.advance) begin
      s2_win  <= win;
      s3_win  <= s2_win;
      s3_lo   <= lo_c;
      s3_hi   <= hi_c;
      s4_win  <= s3_win;
      s4_lo   <= s3_lo;
      s4_hi   <= s3_hi;
      s4_cand <= cand_c;
      s4_low  <= low_c;
      s4_high <= high_c;
    end
  end

endmodule

// ----- hw/rtl/window_edge_classifier.sv -----
// ----------------------------------------------------------------------------
// window_edge_classifier
// Streaming 3x3 edge classifier for 8-bit grey frames. Two line buffers hold
// the previous two rows; the window is built from column registers and
// classified in a short pipeline. Records leave in raster order.
//
//   channel  direction  handshake              payload
//   pix      in         pix_valid / pix_ready  opcode, pixel
//   rec      out        rec_valid / rec_ready  edge position, band values
//   cfg      in         cfg_valid / cfg_ready  cfg_index, cfg_data
//
// One item per clock. A record follows the last item of its window through
// column, classifier and output registers; a frame needs width+1 flush items.
// The rate is set by the line buffer read-modify-write, one column a cycle.
// Reset restores width 1024, height 1024, threshold 20; line buffers are
// not cleared. The output has two entries; input stalls only when both hold.
// ----------------------------------------------------------------------------
module window_edge_classifier #(
  parameter int MAX_WIDTH  = wec_pkg::MAX_WIDTH_DEF,
  parameter int MAX_HEIGHT = wec_pkg::MAX_HEIGHT_DEF
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           pix_valid,
  output logic                           pix_ready,
  input  wec_pkg::pix_item_t             pix,
  output logic                           rec_valid,
  input  logic                           rec_ready,
  output wec_pkg::edge_rec_t             rec,
  input  logic                           cfg_valid,
  output logic                           cfg_ready,
  input  logic [wec_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [wec_pkg::CFG_DATA_W-1:0] cfg_data
);
  import wec_pkg::*;

  localparam int CW = $clog2(MAX_WIDTH);
  localparam int WW = $clog2(MAX_WIDTH + 1);
  localparam int HW = $clog2(MAX_HEIGHT + 1);
  localparam int RW = $clog2(MAX_HEIGHT + 2);
  localparam int W_RESET = (DIM_RESET > MAX_WIDTH) ? MAX_WIDTH : DIM_RESET;
  localparam int H_RESET = (DIM_RESET > MAX_HEIGHT) ? MAX_HEIGHT : DIM_RESET;

  // configuration
  logic [WW-1:0] img_w;
  logic [HW-1:0] img_h;
  pel_t          thr;
  logic [WW-1:0] w_eff;
  logic [HW-1:0] h_eff;
  logic          cfg_wr;
  logic          cfg_hit;

  // arrival position
  logic [CW-1:0] col;
  logic [RW-1:0] row;
  logic          accept;
  logic          en;
  logic          last_col;
  logic          frame_end;

  // column stage
  logic          s1_valid;
  pel_t          s1_new;
  logic          s1_top_clamp;
  logic          s1_bot_clamp;
  logic [CW-1:0] s1_col;
  logic          s1_first;
  logic          s1_second;
  logic          s1_narrow;
  logic          s1_centre;
  logic [9:0]    s1_cx;
  logic [9:0]    s1_cy;

  // line buffers and forwarding
  pel_t          ram1_q;
  pel_t          ram2_q;
  logic          fwd_hit;
  pel_t          fwd_lb1;
  pel_t          fwd_lb2;
  pel_t          lb1_q;
  pel_t          lb2_q;
  pel_t          px_top;
  pel_t          px_mid;
  pel_t          px_bot;
  logic          wr_en;

  // window columns: index 0 top, 2 bottom
  pel_t [2:0]    new_col;
  pel_t [2:0]    col1;
  pel_t [2:0]    col2;
  pel_t [2:0]    left;
  pel_t [2:0]    midc;
  pel_t [2:0]    right;
  win_t          win;
  pipe_ctl_t     ctl;

  // output
  logic          res_valid;
  edge_rec_t     res;
  logic          skid_valid;
  edge_rec_t     skid;

  assign cfg_ready = 1'b1;
  assign cfg_wr    = cfg_valid && cfg_ready;
  assign cfg_hit   = cfg_wr && (cfg_index == REG_IMAGE_WIDTH ||
                                cfg_index == REG_IMAGE_HEIGHT ||
                                cfg_index == REG_EDGE_THRESHOLD);

  always_comb begin
    if (cfg_data == '0) begin
      w_eff = WW'(1);
    end else if (int'(cfg_data) > MAX_WIDTH) begin
      w_eff = WW'(MAX_WIDTH);
    end else begin
      w_eff = WW'(cfg_data);
    end
    if (cfg_data == '0) begin
      h_eff = HW'(1);
    end else if (int'(cfg_data) > MAX_HEIGHT) begin
      h_eff = HW'(MAX_HEIGHT);
    end else begin
      h_eff = HW'(cfg_data);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      img_w <= WW'(W_RESET);
      img_h <= HW'(H_RESET);
      thr   <= THRESH_RESET;
    end else if (cfg_wr) begin
      unique case (cfg_index)
        REG_IMAGE_WIDTH:    img_w <= w_eff;
        REG_IMAGE_HEIGHT:   img_h <= h_eff;
        REG_EDGE_THRESHOLD: thr   <= cfg_data[7:0];
        default: ;
      endcase
    end
  end

  assign en        = !skid_valid;
  assign pix_ready = en;
  assign accept    = pix_valid && pix_ready;
  assign last_col  = WW'(col) == img_w - WW'(1);
  assign frame_end = row == RW'(img_h) + RW'(1);

  always_ff @(posedge clk) begin
    if (rst || cfg_hit) begin
      col <= '0;
      row <= '0;
    end else if (accept) begin
      if (frame_end) begin
        col <= '0;
        row <= '0;
      end else if (last_col) begin
        col <= '0;
        row <= row + RW'(1);
      end else begin
        col <= col + CW'(1);
      end
    end
  end

  // capture the item and its position flags
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
      fwd_hit  <= 1'b0;
    end else begin
      if (en) begin
        s1_valid <= accept;
      end
      if (accept) begin
        fwd_hit <= s1_valid && (s1_col == col);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s1_new       <= (pix.opcode == OP_FLUSH) ? '0 : pix.pixel;
      s1_top_clamp <= row == RW'(1);
      s1_bot_clamp <= row >= RW'(img_h);
      s1_col       <= col;
      s1_first     <= col == '0;
      s1_second    <= col == CW'(1);
      s1_narrow    <= img_w == WW'(1);
      s1_centre    <= (row >= RW'(2)) || (row == RW'(1) && col != '0);
      s1_cx        <= (col == '0) ? 10'(img_w - WW'(1)) : 10'(col - CW'(1));
      s1_cy        <= (col == '0) ? 10'(row - RW'(2)) : 10'(row - RW'(1));
      fwd_lb1      <= px_bot;
      fwd_lb2      <= px_mid;
    end
  end

  // lb1 holds the row above the arriving pixel, lb2 the row above that
  assign wr_en = en && s1_valid;

  wec_ram #(
    .WIDTH ($bits(pel_t)),
    .DEPTH (MAX_WIDTH)
  ) u_lb1 (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (s1_col),
    .wr_data (px_bot),
    .rd_en   (accept),
    .rd_addr (col),
    .rd_data (ram1_q)
  );

  wec_ram #(
    .WIDTH ($bits(pel_t)),
    .DEPTH (MAX_WIDTH)
  ) u_lb2 (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (s1_col),
    .wr_data (px_mid),
    .rd_en   (accept),
    .rd_addr (col),
    .rd_data (ram2_q)
  );

  // forward a write that landed on the address read in the same cycle
  assign lb1_q  = fwd_hit ? fwd_lb1 : ram1_q;
  assign lb2_q  = fwd_hit ? fwd_lb2 : ram2_q;
  assign px_mid = lb1_q;
  assign px_top = s1_top_clamp ? lb1_q : lb2_q;
  assign px_bot = s1_bot_clamp ? lb1_q : s1_new;

  assign new_col = {px_bot, px_mid, px_top};

  always_ff @(posedge clk) begin
    if (en && s1_valid) begin
      col1 <= col2;
      col2 <= new_col;
    end
  end

  // first column of a row closes the last window of the row before
  always_comb begin
    if (s1_first) begin
      left  = s1_narrow ? col2 : col1;
      midc  = col2;
      right = col2;
    end else if (s1_second) begin
      left  = col2;
      midc  = col2;
      right = new_col;
    end else begin
      left  = col1;
      midc  = col2;
      right = new_col;
    end
    for (int r = 0; r < WIN_SIDE; r++) begin
      win.px[r*WIN_SIDE]     = left[r];
      win.px[r*WIN_SIDE + 1] = midc[r];
      win.px[r*WIN_SIDE + 2] = right[r];
    end
    win.cx = s1_cx;
    win.cy = s1_cy;
  end

  assign ctl.valid   = s1_valid && s1_centre;
  assign ctl.advance = en;

  wec_classify u_classify (
    .clk       (clk),
    .rst       (rst),
    .ctl       (ctl),
    .win       (win),
    .thr       (thr),
    .res_valid (res_valid),
    .res       (res)
  );

  // output register with a skid entry behind it
  always_ff @(posedge clk) begin
    if (rst) begin
      rec_valid  <= 1'b0;
      skid_valid <= 1'b0;
    end else if (rec_valid && !rec_ready) begin
      if (en && res_valid) begin
        skid_valid <= 1'b1;
      end
    end else if (skid_valid) begin
      rec_valid  <= 1'b1;
      skid_valid <= 1'b0;
    end else begin
      rec_valid <= res_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (rec_valid && !rec_ready) begin
      if (en && res_valid) begin
        skid <= res;
      end
    end else if (skid_valid) begin
      rec <= skid;
    end else if (res_valid) begin
      rec <= res;
    end
  end

endmodule

// ----- hw/rtl/wec_checker.sv -----
// ----------------------------------------------------------------------------
// wec_checker
// Port-level checks of the window edge classifier, bound to the top level.
// ----------------------------------------------------------------------------
module wec_checker (
  input logic                           clk,
  input logic                           rst,
  input logic                           pix_valid,
  input logic                           pix_ready,
  input wec_pkg::pix_item_t             pix,
  input logic                           rec_valid,
  input logic                           rec_ready,
  input wec_pkg::edge_rec_t             rec,
  input logic                           cfg_valid,
  input logic                           cfg_ready,
  input logic [wec_pkg::CFG_IDX_W-1:0]  cfg_index,
  input logic [wec_pkg::CFG_DATA_W-1:0] cfg_data
);
  import wec_pkg::*;

  // with the output empty the skid entry is empty too
  a_ready_when_drained: assert property (
    @(posedge clk) disable iff (rst)
    !rec_valid |-> pix_ready
  ) else $error("input stalled with no record waiting");

  // low band lies wholly below the high band, both within the window range
  a_band_order: assert property (
    @(posedge clk) disable iff (rst)
    rec_valid |-> (rec.window_min <= rec.low_band_max) &&
                  (rec.low_band_max < rec.high_band_min) &&
                  (rec.high_band_min <= rec.window_max)
  ) else $error("record bands out of order");

  a_rec_hold: assert property (
    @(posedge clk) disable iff (rst)
    rec_valid && !rec_ready |=> rec_valid && $stable(rec)
  ) else $error("record dropped or changed while stalled");

  a_reset_quiet: assert property (
    @(posedge clk)
    $past(rst) |-> !rec_valid
  ) else $error("record presented straight after reset");

endmodule

bind window_edge_classifier wec_checker u_wec_checker (.*);
